FILE: hw/rtl/wstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstk_pkg
// Shared types and constants for the weighted score top-k selector.
// ----------------------------------------------------------------------------
package wstk_pkg;

    localparam int MAX_WINDOWS = 256;
    localparam int MAX_PICKS   = 64;

    localparam int ADDR_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
    localparam int FEAT_W      = 16;
    localparam int PROD_W      = 2 * FEAT_W;
    localparam int SCORE_W     = 33;
    localparam int PICK_W      = 7;
    localparam int IDX_OUT_W   = 8;
    localparam int IDX_EXT_W   = (ADDR_W > IDX_OUT_W) ? ADDR_W : IDX_OUT_W;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 2;

    typedef logic signed [FEAT_W-1:0]  feat_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    localparam score_t TAKEN_SCORE = -score_t'(65536);

    localparam logic [PICK_W-1:0] PICK_MAX = PICK_W'(MAX_PICKS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_A   = 2'd0,
        CFG_WEIGHT_B   = 2'd1,
        CFG_WEIGHT_C   = 2'd2,
        CFG_PICK_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_A = 2'd0,
        STEP_B = 2'd1,
        STEP_C = 2'd2
    } step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_STORE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

FILE: hw/rtl/weighted_score_top_k_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_score_top_k_select_core
// Scores windows with a shared multiplier, then picks the top k by repeated
// max scans over the score memory.
// Load: each transaction passes through accept, 3 multiply steps, accumulate and store.
// Selection: each pick does one memory read per loaded entry, then scan end, result
// update and the result transaction, which an output stall can hold.
// Reset: clears control state and restores the register defaults; the score
// memory is not cleared (only entries written in this batch are read).
// ----------------------------------------------------------------------------
module weighted_score_top_k_select_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wstk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wstk_pkg::FEAT_W-1:0]          cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [wstk_pkg::FEAT_W-1:0]   feature_a,
    input  logic signed [wstk_pkg::FEAT_W-1:0]   feature_b,
    input  logic signed [wstk_pkg::FEAT_W-1:0]   feature_c,
    input  logic                                 final_window,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wstk_pkg::IDX_OUT_W-1:0]       window_index,
    output logic                                 found,
    output logic                                 end_of_list
);

    wstk_pkg::state_t              state_reg, state_next;
    wstk_pkg::feat_t               weight_a_reg, weight_b_reg, weight_c_reg;
    logic [wstk_pkg::PICK_W-1:0]   pick_count_reg;

    wstk_pkg::feat_t               fa_reg, fb_reg, fc_reg;
    wstk_pkg::feat_t               fa_next, fb_next, fc_next;
    logic                          last_reg, last_next;
    wstk_pkg::step_t               step_reg, step_next;
    logic [wstk_pkg::CNT_W-1:0]    loaded_reg, loaded_next;
    logic [wstk_pkg::CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [wstk_pkg::ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    wstk_pkg::score_t              rd_data_reg;
    wstk_pkg::score_t              best_reg, best_next;
    logic [wstk_pkg::ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic                          hit_reg, hit_next;
    logic [wstk_pkg::PICK_W-1:0]   k_reg, k_next;
    logic [wstk_pkg::PICK_W-1:0]   pick_reg, pick_next;

    logic                          out_valid_reg, out_valid_next;
    logic [wstk_pkg::IDX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic                          out_found_reg, out_found_next;
    logic                          out_end_reg, out_end_next;

    wstk_pkg::score_t              mem [wstk_pkg::MAX_WINDOWS];
    logic                          mem_we;
    logic [wstk_pkg::ADDR_W-1:0]   mem_waddr;
    wstk_pkg::score_t              mem_wdata;
    logic                          mem_re;

    logic                          mac_clear, mac_en;
    wstk_pkg::feat_t               mac_weight, mac_feature;
    wstk_pkg::score_t              mac_acc;

    logic                          in_accept, out_accept, cfg_write;
    logic [wstk_pkg::PICK_W-1:0]   k_eff;
    logic [wstk_pkg::IDX_EXT_W-1:0] idx_ext;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign in_stall   = (state_reg != wstk_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign out_valid    = out_valid_reg;
    assign window_index = out_idx_reg;
    assign found        = out_found_reg;
    assign end_of_list  = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_a_reg   <= wstk_pkg::feat_t'(256);
            weight_b_reg   <= wstk_pkg::feat_t'(256);
            weight_c_reg   <= wstk_pkg::feat_t'(256);
            pick_count_reg <= wstk_pkg::PICK_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (wstk_pkg::cfg_idx_t'(cfg_index))
                wstk_pkg::CFG_WEIGHT_A:   weight_a_reg   <= cfg_data;
                wstk_pkg::CFG_WEIGHT_B:   weight_b_reg   <= cfg_data;
                wstk_pkg::CFG_WEIGHT_C:   weight_c_reg   <= cfg_data;
                wstk_pkg::CFG_PICK_COUNT: pick_count_reg <= cfg_data[wstk_pkg::PICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (step_reg)
            wstk_pkg::STEP_A:
            begin
                mac_weight  = weight_a_reg;
                mac_feature = fa_reg;
            end
            wstk_pkg::STEP_B:
            begin
                mac_weight  = weight_b_reg;
                mac_feature = fb_reg;
            end
            default:
            begin
                mac_weight  = weight_c_reg;
                mac_feature = fc_reg;
            end
        endcase
    end

    wstk_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mac_clear),
        .en      (mac_en),
        .weight  (mac_weight),
        .feature (mac_feature),
        .acc     (mac_acc)
    );

    always_comb
    begin
        priority if (pick_count_reg == '0)
        begin
            k_eff = wstk_pkg::PICK_W'(1);
        end
        else if (pick_count_reg > wstk_pkg::PICK_MAX)
        begin
            k_eff = wstk_pkg::PICK_MAX;
        end
        else
        begin
            k_eff = pick_count_reg;
        end
    end

    assign idx_ext = wstk_pkg::IDX_EXT_W'(best_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        fc_next        = fc_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        loaded_next    = loaded_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        hit_next       = hit_reg;
        k_next         = k_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_end_next   = out_end_reg;
        mac_clear      = 1'b0;
        mac_en         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = loaded_reg[wstk_pkg::ADDR_W-1:0];
        mem_wdata      = mac_acc;
        mem_re         = 1'b0;

        // running max over registered read data; strict compare keeps lowest index
        if (rd_vld_reg && (rd_data_reg > best_reg))
        begin
            best_next     = rd_data_reg;
            best_idx_next = rd_idx_reg;
            hit_next      = 1'b1;
        end

        unique case (state_reg)
            wstk_pkg::ST_IDLE:
            begin
                mac_clear = 1'b1;
                if (in_accept)
                begin
                    fa_next    = feature_a;
                    fb_next    = feature_b;
                    fc_next    = feature_c;
                    last_next  = final_window;
                    step_next  = wstk_pkg::STEP_A;
                    state_next = wstk_pkg::ST_MUL;
                end
            end
            wstk_pkg::ST_MUL:
            begin
                mac_en = 1'b1;
                if (step_reg == wstk_pkg::STEP_C)
                begin
                    state_next = wstk_pkg::ST_ACC;
                end
                else
                begin
                    step_next = wstk_pkg::step_t'(step_reg + 2'd1);
                end
            end
            wstk_pkg::ST_ACC:
            begin
                state_next = wstk_pkg::ST_STORE;
            end
            wstk_pkg::ST_STORE:
            begin
                if (loaded_reg < wstk_pkg::CNT_W'(wstk_pkg::MAX_WINDOWS))
                begin
                    mem_we      = 1'b1;
                    loaded_next = loaded_reg + 1'b1;
                end
                if (last_reg)
                begin
                    k_next         = k_eff;
                    pick_next      = '0;
                    scan_addr_next = '0;
                    best_next      = wstk_pkg::TAKEN_SCORE;
                    hit_next       = 1'b0;
                    state_next     = wstk_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = wstk_pkg::ST_IDLE;
                end
            end
            wstk_pkg::ST_SCAN:
            begin
                if (scan_addr_reg < loaded_reg)
                begin
                    mem_re         = 1'b1;
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = scan_addr_reg[wstk_pkg::ADDR_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    state_next = wstk_pkg::ST_DRAIN;
                end
            end
            wstk_pkg::ST_DRAIN:
            begin
                mem_we         = hit_reg;
                mem_waddr      = best_idx_reg;
                mem_wdata      = wstk_pkg::TAKEN_SCORE;
                out_valid_next = 1'b1;
                out_idx_next   = hit_reg ? idx_ext[wstk_pkg::IDX_OUT_W-1:0] : '0;
                out_found_next = hit_reg;
                out_end_next   = ((pick_reg + 1'b1) == k_reg);
                state_next     = wstk_pkg::ST_EMIT;
            end
            wstk_pkg::ST_EMIT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    if (out_end_reg)
                    begin
                        loaded_next = '0;
                        state_next  = wstk_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pick_next      = pick_reg + 1'b1;
                        scan_addr_next = '0;
                        best_next      = wstk_pkg::TAKEN_SCORE;
                        hit_next       = 1'b0;
                        state_next     = wstk_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = wstk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wstk_pkg::ST_IDLE;
            step_reg      <= wstk_pkg::STEP_A;
            loaded_reg    <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            k_reg         <= '0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            loaded_reg    <= loaded_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            k_reg         <= k_next;
            pick_reg      <= pick_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg        <= fa_next;
        fb_reg        <= fb_next;
        fc_reg        <= fc_next;
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
        out_end_reg   <= out_end_next;
    end

    // score memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_addr_reg[wstk_pkg::ADDR_W-1:0]];
        end
    end

endmodule

FILE: hw/rtl/wstk_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstk_mac
// Shared multiply-accumulate unit: one 16x16 product per cycle, registered,
// then added into a 33-bit score accumulator.
// ----------------------------------------------------------------------------
module wstk_mac
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             en,
    input  wstk_pkg::feat_t  weight,
    input  wstk_pkg::feat_t  feature,
    output wstk_pkg::score_t acc
);

    logic             prod_vld_reg;
    logic             prod_vld_next;
    wstk_pkg::prod_t  prod_reg;
    wstk_pkg::prod_t  prod_next;
    wstk_pkg::score_t acc_reg;
    wstk_pkg::score_t acc_next;

    always_comb
    begin
        prod_vld_next = en;
        prod_next     = weight * feature;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + wstk_pkg::score_t'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule
